>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check clocked on clk, masked while arst_n is low
`define HAMW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check that is also evaluated during reset
`define HAMW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/hamw_pkg.sv
// Shared types and constants of the hysteresis alarm/warning monitor
`default_nettype none
package hamw_pkg;

	localparam int LEVEL_W = 16;
	localparam int PACK_W  = 4;
	localparam int PNUM_W  = 5;
	localparam int CODE_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_ALARM_SET  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ALARM_CLR  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_WARN_SET   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_WARN_CLR   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_LOW_SIDE   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_ALARM_CODE = 3'd5;

	// message class codes
	localparam logic CLASS_ALARM = 1'b0;
	localparam logic CLASS_WARN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WARN  = 3'b010,
		ST_ALARM = 3'b100
	} status_t;

	// one status change: optional leading alarm clear, then a final message
	typedef struct packed {
		logic [PNUM_W-1:0]  pack_number;
		logic [LEVEL_W-1:0] value;
		logic [CODE_W-1:0]  code;
		logic               lead_clr;
		logic               fin_class;
		logic               fin_set;
	} job_t;

endpackage
`default_nettype wire

>>> hw/rtl/hysteresis_alarm_warning_monitor_top.sv
// Top level of the hysteresis alarm/warning monitor
//
// Input queue port: a reading (pack_index, reading) is taken on a clock edge
// with push high and full low. Result queue port: the oldest message sits on
// the result ports while empty is low and is taken on an edge with pop high.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per edge;
// cfg_ready is always high. Write only while no reading is in flight.
// Each reading updates the per-pack status in the cycle it is taken and gives
// zero, one or two messages via the change queue and the single message
// output register, which sets the rate: one message per cycle while the
// receiver pops; a reading that causes two messages stays queued until its
// second is loaded, others flow at one per cycle. A two-entry change queue
// lets readings arrive while the receiver stalls; full rises once it fills.
// Reset clears all levels to zero (channel disabled), every pack to idle and
// not armed, and empties the queue and the output register.
`default_nettype none
module hysteresis_alarm_warning_monitor_top import hamw_pkg::*; #(
	parameter int NUM_PACKS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CIDX_W-1:0]         cfg_index,
	input  wire logic [LEVEL_W-1:0]        cfg_data,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [PACK_W-1:0]         pack_index,
	input  wire logic signed [LEVEL_W-1:0] reading,
	output logic                           empty,
	input  wire logic                      pop,
	output logic                           message_class,
	output logic                           set_not_clear,
	output logic [CODE_W-1:0]              alarm_code_out,
	output logic [PNUM_W-1:0]              pack_number,
	output logic [LEVEL_W-1:0]             reported_value,
	output logic                           last_message
);

	logic q_full, q_push, rd_valid, rd_en;
	job_t q_job, rd_job;

	hamw_front #(.NUM_PACKS(NUM_PACKS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.pack_index (pack_index),
		.reading    (reading),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_job)
	);

	hamw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_job   (q_job),
		.q_full   (q_full),
		.rd_valid (rd_valid),
		.rd_en    (rd_en),
		.rd_job   (rd_job)
	);

	hamw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd_valid       (rd_valid),
		.rd_job         (rd_job),
		.rd_en          (rd_en),
		.empty          (empty),
		.pop            (pop),
		.message_class  (message_class),
		.set_not_clear  (set_not_clear),
		.alarm_code_out (alarm_code_out),
		.pack_number    (pack_number),
		.reported_value (reported_value),
		.last_message   (last_message)
	);

endmodule
`default_nettype wire

>>> hw/rtl/hamw_front.sv
// Front end: configuration registers, per-pack status and change classification
`default_nettype none
module hamw_front import hamw_pkg::*; #(
	parameter int NUM_PACKS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CIDX_W-1:0]         cfg_index,
	input  wire logic [LEVEL_W-1:0]        cfg_data,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [PACK_W-1:0]         pack_index,
	input  wire logic signed [LEVEL_W-1:0] reading,
	input  wire logic                      q_full,
	output logic                           q_push,
	output job_t                           q_job
);

	localparam int PIDX_W = (NUM_PACKS > 1) ? $clog2(NUM_PACKS) : 1;

	logic signed [LEVEL_W-1:0] alarm_set_q, alarm_clr_q, warn_set_q, warn_clr_q;
	logic                      low_side_q;
	logic [CODE_W-1:0]         code_q;

	status_t status_q [NUM_PACKS];
	logic    armed_q  [NUM_PACKS];

	logic              accept, in_range, enabled, update;
	logic [PIDX_W-1:0] pidx;
	status_t           old_st, nxt_st;
	logic              old_arm, nxt_arm;
	logic              b_aset, b_aclr, b_wset, b_wclr;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_set_q <= '0;
			alarm_clr_q <= '0;
			warn_set_q  <= '0;
			warn_clr_q  <= '0;
			low_side_q  <= 1'b0;
			code_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALARM_SET:  alarm_set_q <= cfg_data;
				REG_ALARM_CLR:  alarm_clr_q <= cfg_data;
				REG_WARN_SET:   warn_set_q  <= cfg_data;
				REG_WARN_CLR:   warn_clr_q  <= cfg_data;
				REG_LOW_SIDE:   low_side_q  <= cfg_data[0];
				REG_ALARM_CODE: code_q      <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_range = 32'(pack_index) < NUM_PACKS;
	assign enabled  = alarm_set_q != '0;
	assign pidx     = PIDX_W'(pack_index);
	assign old_st   = status_q[pidx];
	assign old_arm  = armed_q[pidx];

	assign b_aset = low_side_q ? (reading < alarm_set_q) : (reading > alarm_set_q);
	assign b_aclr = low_side_q ? (reading < alarm_clr_q) : (reading > alarm_clr_q);
	assign b_wset = low_side_q ? (reading < warn_set_q)  : (reading > warn_set_q);
	assign b_wclr = low_side_q ? (reading < warn_clr_q)  : (reading > warn_clr_q);

	always_comb begin
		nxt_st  = old_st;
		nxt_arm = old_arm;
		case (old_st)
			ST_IDLE: begin
				if (b_aset) begin
					nxt_st  = ST_ALARM;
					nxt_arm = 1'b1;
				end else if (b_aclr || b_wset) begin
					if (old_arm) nxt_st = ST_WARN;
				end else if (!b_wclr) begin
					nxt_arm = 1'b1;
				end
			end
			ST_WARN: begin
				if (b_aset) begin
					nxt_st  = ST_ALARM;
					nxt_arm = 1'b1;
				end else if (!(b_aclr || b_wset || b_wclr)) begin
					nxt_st  = ST_IDLE;
					nxt_arm = 1'b1;
				end
			end
			ST_ALARM: begin
				if (b_aset) begin
					nxt_arm = 1'b1;
				end else if (b_aclr) begin
					nxt_st = ST_ALARM;
				end else if (b_wset || b_wclr) begin
					nxt_st = old_arm ? ST_WARN : ST_IDLE;
				end else begin
					nxt_st  = ST_IDLE;
					nxt_arm = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign update = accept && in_range && enabled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PACKS; i++) begin
				status_q[i] <= ST_IDLE;
				armed_q[i]  <= 1'b0;
			end
		end else if (update) begin
			status_q[pidx] <= nxt_st;
			armed_q[pidx]  <= nxt_arm;
		end
	end

	assign q_push = update && (nxt_st != old_st);

	always_comb begin
		q_job.pack_number = PNUM_W'(pack_index) + PNUM_W'(1);
		q_job.value       = reading;
		q_job.code        = code_q;
		q_job.lead_clr    = (old_st == ST_ALARM) && (nxt_st != ST_ALARM);
		q_job.fin_class   = (nxt_st == ST_ALARM) ? CLASS_ALARM : CLASS_WARN;
		q_job.fin_set     = nxt_st != ST_IDLE;
	end

endmodule
`default_nettype wire

>>> hw/rtl/hamw_queue.sv
// Short request queue between the front end and the message sequencer
`default_nettype none
module hamw_queue import hamw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_job,
	output logic      q_full,
	output logic      rd_valid,
	input  wire logic rd_en,
	output job_t      rd_job
);

	job_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign q_full   = count_q == (Q_AW+1)'(Q_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (32'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + Q_AW'(1);
			if (rd_en)
				rd_ptr_q <= (32'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + Q_AW'(1);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/hamw_back.sv
// Back end: expands each queued change into one or two messages
`default_nettype none
module hamw_back import hamw_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_valid,
	input  wire job_t          rd_job,
	output logic               rd_en,
	output logic               empty,
	input  wire logic          pop,
	output logic               message_class,
	output logic               set_not_clear,
	output logic [CODE_W-1:0]  alarm_code_out,
	output logic [PNUM_W-1:0]  pack_number,
	output logic [LEVEL_W-1:0] reported_value,
	output logic               last_message
);

	logic               out_valid_q, sub_q;
	logic               cls_q, set_q, last_q;
	logic [CODE_W-1:0]  code_q;
	logic [PNUM_W-1:0]  pnum_q;
	logic [LEVEL_W-1:0] value_q;
	logic               load, lead;

	// load the next message whenever the output slot is free or being taken
	assign load  = rd_valid && (!out_valid_q || pop);
	assign lead  = rd_job.lead_clr && !sub_q;
	assign rd_en = load && !lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= lead;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cls_q   <= lead ? CLASS_ALARM : rd_job.fin_class;
			set_q   <= lead ? 1'b0 : rd_job.fin_set;
			last_q  <= !lead;
			code_q  <= rd_job.code;
			pnum_q  <= rd_job.pack_number;
			value_q <= rd_job.value;
		end
	end

	assign empty          = !out_valid_q;
	assign message_class  = cls_q;
	assign set_not_clear  = set_q;
	assign alarm_code_out = code_q;
	assign pack_number    = pnum_q;
	assign reported_value = value_q;
	assign last_message   = last_q;

endmodule
`default_nettype wire

>>> hw/rtl/hamw_checker.sv
// Port-level checks of the monitor, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module hamw_checker import hamw_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic               message_class,
	input wire logic               set_not_clear,
	input wire logic [CODE_W-1:0]  alarm_code_out,
	input wire logic [PNUM_W-1:0]  pack_number,
	input wire logic [LEVEL_W-1:0] reported_value,
	input wire logic               last_message
);

	`HAMW_ASSERT(a_hold_on_stall, !empty && !pop |=> !empty && $stable(reported_value) && $stable(pack_number) && $stable(message_class) && $stable(last_message), "result changed while stalled")
	`HAMW_ASSERT(a_pack_nonzero, !empty |-> pack_number != '0, "pack number zero")
	`HAMW_ASSERT(a_lead_is_clear, !empty && !last_message |-> message_class == CLASS_ALARM && !set_not_clear, "leading message is not alarm clear")
	`HAMW_ASSERT(a_pair_follows, !empty && pop && !last_message |=> !empty && message_class == CLASS_WARN && last_message && $stable(pack_number) && $stable(reported_value) && $stable(alarm_code_out), "second message of a pair missing")

endmodule

bind hysteresis_alarm_warning_monitor_top hamw_checker u_hamw_checker (.*);
`default_nettype wire

>>> test/tb_hysteresis_alarm_warning_monitor_top.sv
// Self-checking testbench for the hysteresis alarm/warning monitor: directed table, random phases
`default_nettype none
module tb_hysteresis_alarm_warning_monitor_top import hamw_pkg::*;;

	localparam int NPACKS      = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN       = 6;
	localparam int NUM_PHASES  = 8;

	typedef enum logic {ROW_READ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic               cls;
		logic               is_set;
		logic [CODE_W-1:0]  code;
		logic [PNUM_W-1:0]  pnum;
		logic [LEVEL_W-1:0] value;
		logic               last_flag;
	} msg_t;

	typedef struct {
		row_kind_t          kind;
		logic [CIDX_W-1:0]  reg_idx;
		logic [PACK_W-1:0]  pack;
		logic [LEVEL_W-1:0] value;
		bit                 typed;
		int                 n_msg;
		logic               fin_cls;
		logic               fin_set;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [LEVEL_W-1:0]  cfg_data = '0;
	logic                push = 1'b0;
	logic                full;
	logic [PACK_W-1:0]   pack_index = '0;
	logic [LEVEL_W-1:0]  reading = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic                message_class;
	logic                set_not_clear;
	logic [CODE_W-1:0]   alarm_code_out;
	logic [PNUM_W-1:0]   pack_number;
	logic [LEVEL_W-1:0]  reported_value;
	logic                last_message;

	hysteresis_alarm_warning_monitor_top #(.NUM_PACKS(NPACKS)) u_top (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.push, .full, .pack_index, .reading, .empty, .pop,
		.message_class, .set_not_clear, .alarm_code_out, .pack_number,
		.reported_value, .last_message
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the channel configuration and per-pack status
	logic signed [LEVEL_W-1:0] lvl_aset, lvl_aclr, lvl_wset, lvl_wclr;
	logic                      low_side;
	logic [CODE_W-1:0]         code_reg;
	status_t                   pack_status [NPACKS];
	logic                      pack_armed [NPACKS];

	msg_t pending_msgs [$];
	msg_t next_msgs [$];
	int   errors = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   phase_levels [4];

	stim_row_t dir_rows [];

	function automatic logic is_beyond(logic signed [LEVEL_W-1:0] x,
			logic signed [LEVEL_W-1:0] lvl);
		return low_side ? (x < lvl) : (x > lvl);
	endfunction

	function automatic msg_t make_msg(logic cls, logic is_set, logic [PACK_W-1:0] p,
			logic [LEVEL_W-1:0] raw, logic last_flag);
		msg_t m;
		m.cls       = cls;
		m.is_set    = is_set;
		m.code      = code_reg;
		m.pnum      = PNUM_W'(p) + 1'b1;
		m.value     = raw;
		m.last_flag = last_flag;
		return m;
	endfunction

	// status update for one reading; fills next_msgs with the messages it causes
	function automatic void predict_messages(logic [PACK_W-1:0] p, logic [LEVEL_W-1:0] raw);
		logic signed [LEVEL_W-1:0] x;
		status_t                   was, now;
		logic                      armed;
		x = raw;
		was = pack_status[p];
		now = was;
		armed = pack_armed[p];
		next_msgs.delete();
		if (lvl_aset == 0)
			return;
		case (was)
			ST_IDLE: begin
				if (is_beyond(x, lvl_aset)) begin
					now = ST_ALARM;
					armed = 1'b1;
				end else if (is_beyond(x, lvl_aclr) || is_beyond(x, lvl_wset)) begin
					if (armed)
						now = ST_WARN;
				end else if (!is_beyond(x, lvl_wclr)) begin
					armed = 1'b1;
				end
			end
			ST_WARN: begin
				if (is_beyond(x, lvl_aset)) begin
					now = ST_ALARM;
					armed = 1'b1;
				end else if (!(is_beyond(x, lvl_aclr) || is_beyond(x, lvl_wset) ||
						is_beyond(x, lvl_wclr))) begin
					now = ST_IDLE;
					armed = 1'b1;
				end
			end
			ST_ALARM: begin
				if (is_beyond(x, lvl_aset)) begin
					armed = 1'b1;
				end else if (is_beyond(x, lvl_aclr)) begin
					now = ST_ALARM;
				end else if (is_beyond(x, lvl_wset) || is_beyond(x, lvl_wclr)) begin
					now = armed ? ST_WARN : ST_IDLE;
				end else begin
					now = ST_IDLE;
					armed = 1'b1;
				end
			end
			default: ;
		endcase
		pack_status[p] = now;
		pack_armed[p] = armed;
		if (now == was)
			return;
		if (was == ST_ALARM && now != ST_ALARM)
			next_msgs.push_back(make_msg(CLASS_ALARM, 1'b0, p, raw, 1'b0));
		if (now == ST_ALARM)
			next_msgs.push_back(make_msg(CLASS_ALARM, 1'b1, p, raw, 1'b1));
		else
			next_msgs.push_back(make_msg(CLASS_WARN, now == ST_WARN, p, raw, 1'b1));
	endfunction

	// call at a falling edge; leaves cfg_valid high for a following write
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [LEVEL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ALARM_SET:  lvl_aset = data;
			REG_ALARM_CLR:  lvl_aclr = data;
			REG_WARN_SET:   lvl_wset = data;
			REG_WARN_CLR:   lvl_wclr = data;
			REG_LOW_SIDE:   low_side = data[0];
			REG_ALARM_CODE: code_reg = data[CODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// call at a falling edge; returns at the falling edge after the request is taken
	task automatic send_reading(logic [PACK_W-1:0] p, logic [LEVEL_W-1:0] r,
			bit typed = 1'b0, int n_msg = 0, logic fin_cls = 1'b0, logic fin_set = 1'b0);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		pack_index <= p;
		reading <= r;
		do @(posedge clk); while (full);
		predict_messages(p, r);
		if (typed) begin
			if (n_msg == 2)
				pending_msgs.push_back(make_msg(CLASS_ALARM, 1'b0, p, r, 1'b0));
			if (n_msg > 0)
				pending_msgs.push_back(make_msg(fin_cls, fin_set, p, r, 1'b1));
		end else begin
			foreach (next_msgs[k])
				pending_msgs.push_back(next_msgs[k]);
		end
		@(negedge clk);
	endtask

	task automatic settle_block();
		push <= 1'b0;
		while (pending_msgs.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic configure_phase(int ph);
		int   base, dir, aset, aclr, wset, wclr;
		logic ls;
		logic [CODE_W-1:0] code;
		ls = 1'($urandom_range(0, 1));
		code = CODE_W'($urandom_range(0, 7));
		base = int'($urandom_range(0, 40000)) - 20000;
		dir = ls ? -1 : 1;
		wclr = base;
		wset = wclr + dir * int'($urandom_range(0, 300));
		aclr = wset + dir * int'($urandom_range(0, 300));
		aset = aclr + dir * int'($urandom_range(0, 300));
		if ($urandom_range(0, 3) == 0) begin
			// unordered levels
			aset = int'($urandom_range(0, 65535)) - 32768;
			aclr = int'($urandom_range(0, 65535)) - 32768;
			wset = int'($urandom_range(0, 65535)) - 32768;
			wclr = int'($urandom_range(0, 65535)) - 32768;
		end
		case (ph)
			0: code = '0;
			1: begin
				ls = 1'b0;
				aset = -32768;
				aclr = 32767;
				wset = -32768;
				wclr = 32767;
				code = '1;
			end
			3: begin
				ls = 1'b1;
				aset = 32767;
				code = '1;
			end
			5: begin
				ls = 1'b0;
				aset = 32767;
			end
			default: ;
		endcase
		if (ph == 2)
			aset = 0;
		else if (aset == 0)
			aset = 1;
		phase_levels = '{aset, aclr, wset, wclr};
		write_reg(REG_ALARM_SET, LEVEL_W'(aset));
		write_reg(REG_ALARM_CLR, LEVEL_W'(aclr));
		write_reg(REG_WARN_SET, LEVEL_W'(wset));
		write_reg(REG_WARN_CLR, LEVEL_W'(wclr));
		write_reg(REG_LOW_SIDE, LEVEL_W'(ls));
		write_reg(REG_ALARM_CODE, LEVEL_W'(code));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [LEVEL_W-1:0] pick_reading();
		int v;
		case ($urandom_range(0, 9))
			0: v = 32767;
			1: v = -32768;
			2, 3: v = int'($urandom_range(0, 65535)) - 32768;
			default: v = phase_levels[2'($urandom_range(0, 3))] + int'($urandom_range(0, 8)) - 4;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return LEVEL_W'(v);
	endfunction

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		msg_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{message_class, set_not_clear, alarm_code_out, pack_number,
				reported_value, last_message};
			if (pending_msgs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected message: class %0d set %0d code %0d pack %0d value %h last %0d",
						got.cls, got.is_set, got.code, got.pnum, got.value, got.last_flag);
			end else begin
				want = pending_msgs.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp/act: class %0d/%0d set %0d/%0d code %0d/%0d pack %0d/%0d value %h/%h last %0d/%0d",
							want.cls, got.cls, want.is_set, got.is_set, want.code, got.code,
							want.pnum, got.pnum, want.value, got.value,
							want.last_flag, got.last_flag);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int n_items;
		lvl_aset = '0;
		lvl_aclr = '0;
		lvl_wset = '0;
		lvl_wclr = '0;
		low_side = 1'b0;
		code_reg = '0;
		foreach (pack_status[i]) begin
			pack_status[i] = ST_IDLE;
			pack_armed[i] = 1'b0;
		end
		dir_rows = '{
			// disabled after reset
			'{ROW_READ, '0, 4'd0, 16'h7FFF, 1'b1, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd15, 16'h8000, 1'b1, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_SET, '0, 16'd1000, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_CLR, '0, 16'd800, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_WARN_SET, '0, 16'd600, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_WARN_CLR, '0, 16'd400, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_LOW_SIDE, '0, 16'd0, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_CODE, '0, 16'd5, 1'b0, 0, 1'b0, 1'b0},
			// pack 0: not armed, then armed, through warning and alarm
			'{ROW_READ, '0, 4'd0, 16'd700, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'd100, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'd700, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'd500, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'h7FFF, 1'b1, 1, CLASS_ALARM, 1'b1},
			'{ROW_READ, '0, 4'd0, 16'd900, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'd700, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'h7FFF, 1'b1, 1, CLASS_ALARM, 1'b1},
			'{ROW_READ, '0, 4'd0, 16'h8000, 1'b1, 2, CLASS_WARN, 1'b0},
			// pack 1: between clear levels stays unarmed; level itself is not beyond
			'{ROW_READ, '0, 4'd1, 16'd500, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd1, 16'd700, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd1, 16'd1000, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd1, 16'd1001, 1'b0, 0, 1'b0, 1'b0},
			// low side checking
			'{ROW_CFG, REG_LOW_SIDE, '0, 16'd1, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_SET, '0, 16'(-1000), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_CLR, '0, 16'(-800), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_WARN_SET, '0, 16'(-600), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_WARN_CLR, '0, 16'(-400), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_CODE, '0, 16'd2, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd2, 16'h8000, 1'b1, 1, CLASS_ALARM, 1'b1},
			'{ROW_READ, '0, 4'd2, 16'h7FFF, 1'b1, 2, CLASS_WARN, 1'b0},
			'{ROW_READ, '0, 4'd2, 16'(-700), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd1, 16'h8000, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd1, 16'(-500), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'(-1000), 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd0, 16'(-300), 1'b0, 0, 1'b0, 1'b0},
			// channel switched off again: state held, no messages
			'{ROW_CFG, REG_ALARM_CODE, '0, 16'd7, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_CFG, REG_ALARM_SET, '0, 16'd0, 1'b0, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd2, 16'h7FFF, 1'b1, 0, 1'b0, 1'b0},
			'{ROW_READ, '0, 4'd3, 16'h8000, 1'b1, 0, 1'b0, 1'b0}
		};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 51;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (i > 0 && dir_rows[i-1].kind == ROW_READ)
					settle_block();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
				if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_reading(dir_rows[i].pack, dir_rows[i].value, dir_rows[i].typed,
					dir_rows[i].n_msg, dir_rows[i].fin_cls, dir_rows[i].fin_set);
			end
		end
		settle_block();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 51;
			end else if (ph < 6) begin
				send_idle_pct = 51;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure_phase(ph);
			// receiver holds off while readings keep coming, so the block fills up
			if (ph == 1 || ph == 6)
				hold_requests++;
			n_items = (ph == 2) ? 30 : 100;
			for (int k = 0; k < n_items; k++) begin
				if (ph == 4 && k == n_items / 2)
					settle_block();
				send_reading(($urandom_range(0, 1) != 0) ? PACK_W'($urandom_range(0, 3)) :
					PACK_W'($urandom_range(0, NPACKS - 1)), pick_reading());
			end
			settle_block();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
